FILE: design/mves_pkg.sv
// mves_pkg: shared types and constants for the eviction victim selector.
// Used by mves_ctrl, mves_dp and multi_victim_evict_selector. No dependencies.
`timescale 1ns / 1ps

package mves_pkg;

  localparam int SLOT_W      = 6;   // width of a slot field on the ports
  localparam int SKIP_W      = 7;
  localparam int SIZE_W      = 32;
  localparam int STAMP_W     = 64;
  localparam int COUNT_W     = 32;
  localparam int NEED_W      = 40;
  localparam int MAX_VICTIMS = 64;  // victims per request
  localparam int VIDX_W      = 6;   // index into victim list
  localparam int VCNT_W      = 7;   // victim count, holds MAX_VICTIMS

  localparam logic [1:0] POL_FIFO = 2'd0;
  localparam logic [1:0] POL_LRU  = 2'd1;
  localparam logic [1:0] POL_LFU  = 2'd2;

  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_EVICT = 1'b1;

  // controller -> datapath
  typedef struct packed {
    logic tbl_wr;      // load one table slot
    logic req_load;    // capture evict request, clear victim state
    logic scan_begin;  // start a minimum search pass
    logic take;        // commit best entry as next victim
    logic emit_rd;     // read victim list entry
    logic emit_load;   // load output register with that victim
    logic out_fail;    // load failure result
    logic out_zero;    // load zero-need success result
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic scan_done;
    logic found;
    logic enough;
    logic full;
    logic empty;
    logic out_taken;
    logic out_last;
  } status_t;

endpackage

FILE: design/mves_dp.sv
// mves_dp: object table, search unit, victim list and output register.
// Depends on mves_pkg.
`timescale 1ns / 1ps

module mves_dp #(
  parameter int ENTRIES = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  mves_pkg::cmd_t                cmd,
  output mves_pkg::status_t             status,
  input  logic                          cfg_we,
  input  logic [1:0]                    cfg_data,
  input  logic [mves_pkg::SLOT_W-1:0]   in_slot,
  input  logic                          in_entry_valid,
  input  logic [mves_pkg::SIZE_W-1:0]   in_object_size,
  input  logic [mves_pkg::STAMP_W-1:0]  in_created_at,
  input  logic [mves_pkg::STAMP_W-1:0]  in_last_used_at,
  input  logic [mves_pkg::COUNT_W-1:0]  in_use_count,
  input  logic [mves_pkg::NEED_W-1:0]   in_bytes_needed,
  input  logic [mves_pkg::SKIP_W-1:0]   in_skip_slot,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [39:0]                   m_tdata,
  output logic                          m_tlast
);

  localparam int IW  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int SW  = mves_pkg::SLOT_W;
  localparam int ZW  = mves_pkg::SIZE_W;
  localparam int KW  = mves_pkg::STAMP_W;
  localparam int CW  = mves_pkg::COUNT_W;
  localparam int NW  = mves_pkg::NEED_W;
  localparam int VW  = mves_pkg::VCNT_W;
  localparam int XW  = mves_pkg::VIDX_W;
  localparam int MW  = ZW + KW + KW + CW;
  localparam int LW  = IW + ZW;

  logic [1:0]          policy;
  logic [MW-1:0]       tbl_mem [ENTRIES];
  logic [ENTRIES-1:0]  slot_valid;
  logic [ENTRIES-1:0]  picked;
  logic [LW-1:0]       vlist [mves_pkg::MAX_VICTIMS];

  logic [NW-1:0]       need;
  logic [mves_pkg::SKIP_W-1:0] skip;
  logic [NW-1:0]       freed;
  logic [VW-1:0]       vcount;
  logic [XW-1:0]       eidx;

  logic [IW-1:0]       scan_idx;
  logic                scan_run;
  logic                cmp_v;
  logic [IW-1:0]       cmp_slot;
  logic [MW-1:0]       rd_q;

  logic                found;
  logic [KW-1:0]       best_key;
  logic [ZW-1:0]       best_size;
  logic [IW-1:0]       best_slot;

  logic [LW-1:0]       vq;

  logic                out_success;
  logic                out_present;
  logic [SW-1:0]       out_slot;
  logic [ZW-1:0]       out_size;

  logic [IW-1:0]       wr_idx;
  logic                wr_ok;
  logic [ZW-1:0]       cand_size;
  logic [KW-1:0]       cand_key;
  logic                eligible;
  logic                better;

  assign wr_idx = IW'(in_slot);
  assign wr_ok  = 32'(in_slot) < ENTRIES;

  // rd_q layout: size, created, last used, use count from the low end
  assign cand_size = rd_q[ZW-1:0];
  always_comb begin
    case (policy)
      mves_pkg::POL_LRU: cand_key = rd_q[ZW+KW +: KW];
      mves_pkg::POL_LFU: cand_key = KW'(rd_q[ZW+2*KW +: CW]);
      default:           cand_key = rd_q[ZW +: KW];
    endcase
  end

  assign eligible = slot_valid[cmp_slot] && !picked[cmp_slot] &&
                    (32'(cmp_slot) != 32'(skip));
  // ascending scan: a later slot never wins a full tie
  assign better = !found || (cand_key < best_key) ||
                  ((cand_key == best_key) && (cand_size < best_size));

  always_ff @(posedge clk) begin
    if (cmd.tbl_wr && wr_ok) begin
      tbl_mem[wr_idx] <= {in_use_count, in_last_used_at, in_created_at, in_object_size};
    end
    if (scan_run) begin
      rd_q <= tbl_mem[scan_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take && found) begin
      vlist[vcount[XW-1:0]] <= {best_slot, best_size};
    end
    if (cmd.emit_rd) begin
      vq <= vlist[eidx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      policy     <= mves_pkg::POL_FIFO;
      slot_valid <= '0;
      picked     <= '0;
      scan_run   <= 1'b0;
      cmp_v      <= 1'b0;
      found      <= 1'b0;
      m_tvalid   <= 1'b0;
      freed      <= '0;
      vcount     <= '0;
      eidx       <= '0;
    end else begin
      if (cfg_we) begin
        policy <= cfg_data;
      end
      if (cmd.tbl_wr && wr_ok) begin
        slot_valid[wr_idx] <= in_entry_valid;
      end
      if (cmd.req_load) begin
        need   <= in_bytes_needed;
        skip   <= in_skip_slot;
        picked <= '0;
        freed  <= '0;
        vcount <= '0;
        eidx   <= '0;
      end

      // search pass: read at scan_idx, compare in the following cycle
      cmp_v    <= scan_run;
      cmp_slot <= scan_idx;
      if (cmd.scan_begin) begin
        scan_idx <= '0;
        scan_run <= 1'b1;
        found    <= 1'b0;
      end else if (scan_run) begin
        if (scan_idx == IW'(ENTRIES - 1)) begin
          scan_run <= 1'b0;
        end
        scan_idx <= scan_idx + IW'(1);
      end
      if (cmp_v && eligible && better) begin
        found     <= 1'b1;
        best_key  <= cand_key;
        best_size <= cand_size;
        best_slot <= cmp_slot;
      end

      if (cmd.take && found) begin
        picked[best_slot] <= 1'b1;
        freed  <= freed + NW'(best_size);
        vcount <= vcount + VW'(1);
      end

      // output register
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (cmd.emit_load) begin
        m_tvalid    <= 1'b1;
        out_success <= 1'b1;
        out_present <= 1'b1;
        out_slot    <= SW'(vq[LW-1:ZW]);
        out_size    <= vq[ZW-1:0];
        m_tlast     <= (VW'(eidx) + VW'(1)) == vcount;
        slot_valid[vq[LW-1:ZW]] <= 1'b0;
        eidx        <= eidx + XW'(1);
      end else if (cmd.out_fail || cmd.out_zero) begin
        m_tvalid    <= 1'b1;
        out_success <= cmd.out_zero;
        out_present <= 1'b0;
        out_slot    <= '0;
        out_size    <= '0;
        m_tlast     <= 1'b1;
      end
    end
  end

  assign m_tdata = {out_size, out_slot, out_present, out_success};

  assign status.scan_done = cmp_v && !scan_run;
  assign status.found     = found;
  assign status.enough    = freed >= need;
  assign status.full      = vcount == VW'(mves_pkg::MAX_VICTIMS);
  assign status.empty     = vcount == '0;
  assign status.out_taken = m_tvalid && m_tready;
  assign status.out_last  = m_tlast;

endmodule

FILE: design/mves_ctrl.sv
// mves_ctrl: request sequencer for the eviction victim selector.
// Depends on mves_pkg; drives mves_dp through cmd_t / status_t.
`timescale 1ns / 1ps

module mves_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  input  logic              mode,
  output logic              s_tready,
  output mves_pkg::cmd_t    cmd,
  input  mves_pkg::status_t status
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SCAN,
    ST_PICK,
    ST_EMIT_RD,
    ST_EMIT_LD,
    ST_EMIT_WAIT,
    ST_FINAL
  } state_t;

  state_t state;
  logic   accept;

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;

  always_comb begin
    cmd            = '0;
    cmd.tbl_wr     = accept && (mode == mves_pkg::MODE_WRITE);
    cmd.req_load   = accept && (mode == mves_pkg::MODE_EVICT);
    unique case (state)
      ST_CHECK: begin
        if (status.enough) begin
          cmd.out_zero = status.empty;
        end else if (status.full) begin
          cmd.out_fail = 1'b1;
        end else begin
          cmd.scan_begin = 1'b1;
        end
      end
      ST_PICK: begin
        cmd.take     = status.found;
        cmd.out_fail = !status.found;
      end
      ST_EMIT_RD: cmd.emit_rd   = 1'b1;
      ST_EMIT_LD: cmd.emit_load = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (cmd.req_load) state <= ST_CHECK;
        end
        ST_CHECK: begin
          if (status.enough) begin
            state <= status.empty ? ST_FINAL : ST_EMIT_RD;
          end else if (status.full) begin
            state <= ST_FINAL;
          end else begin
            state <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (status.scan_done) state <= ST_PICK;
        end
        ST_PICK: begin
          state <= status.found ? ST_CHECK : ST_FINAL;
        end
        ST_EMIT_RD: state <= ST_EMIT_LD;
        ST_EMIT_LD: state <= ST_EMIT_WAIT;
        ST_EMIT_WAIT: begin
          if (status.out_taken) state <= status.out_last ? ST_IDLE : ST_EMIT_RD;
        end
        ST_FINAL: begin
          if (status.out_taken) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

FILE: design/multi_victim_evict_selector.sv
// multi_victim_evict_selector: top level, object table with FIFO/LRU/LFU victim pick.
// Depends on mves_pkg, mves_ctrl, mves_dp.
//
//  channel  dir  handshake            payload
//  s_*      in   s_tvalid/s_tready    s_tdata (table write or evict request), s_tuser mode
//  m_*      out  m_tvalid/m_tready    m_tdata (one result), m_tlast last result of request
//  cfg_*    in   cfg_we               cfg_data policy, no read-back
//
// An evict request runs one search pass per victim through the single table read port
// (check, read sweep, pick), then emits each victim in turn (read list, load output
// register, wait for the sink).
// Reset clears the valid bits and control state; table contents are loaded by writes.
// s_tready is high only while idle; a stalled m_tready holds the sequencer in place.
`timescale 1ns / 1ps

module multi_victim_evict_selector #(
  parameter int ENTRIES = 64
) (
  input  logic         clk,
  input  logic         rst,
  // request channel
  input  logic         s_tvalid,
  output logic         s_tready,
  // tdata from bit 0: slot[6], entry_valid[1], object_size[32], created_at[64],
  // last_used_at[64], use_count[32], bytes_needed[40], skip_slot[7], zero pad[2]
  input  logic [247:0] s_tdata,
  input  logic         s_tuser,   // mode: 0 write slot, 1 evict
  // result channel
  output logic         m_tvalid,
  input  logic         m_tready,
  // tdata from bit 0: success[1], victim_present[1], victim_slot[6], victim_size[32]
  output logic [39:0]  m_tdata,
  output logic         m_tlast,
  // policy register
  input  logic         cfg_we,
  input  logic [1:0]   cfg_data
);

  mves_pkg::cmd_t    cmd;
  mves_pkg::status_t status;

  mves_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .mode     (s_tuser),
    .s_tready (s_tready),
    .cmd      (cmd),
    .status   (status)
  );

  // request fields unpacked from s_tdata
  mves_dp #(
    .ENTRIES (ENTRIES)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .cfg_we          (cfg_we),
    .cfg_data        (cfg_data),
    .in_slot         (s_tdata[5:0]),
    .in_entry_valid  (s_tdata[6]),
    .in_object_size  (s_tdata[38:7]),
    .in_created_at   (s_tdata[102:39]),
    .in_last_used_at (s_tdata[166:103]),
    .in_use_count    (s_tdata[198:167]),
    .in_bytes_needed (s_tdata[238:199]),
    .in_skip_slot    (s_tdata[245:239]),
    .m_tvalid        (m_tvalid),
    .m_tready        (m_tready),
    .m_tdata         (m_tdata),
    .m_tlast         (m_tlast)
  );

endmodule
